// ===== rtl/core/lsc_pkg.sv =====
// Shared types, constants and the outcode function for the line segment clipper.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package lsc_pkg;

   localparam int COORD_W   = 16;   // Q11.4 coordinate
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int MAG_W     = 32;   // |product| < 2**32
   localparam int DIV_CNT_W = $clog2(MAG_W);
   localparam int CSR_IDX_W = 2;

   // outcode bits
   localparam logic [3:0] OC_BOTTOM = 4'd1;
   localparam logic [3:0] OC_LEFT   = 4'd2;
   localparam logic [3:0] OC_TOP    = 4'd4;
   localparam logic [3:0] OC_RIGHT  = 4'd8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_BOTTOM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_RIGHT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_TOP    = 2'd3;

   localparam logic signed [COORD_W-1:0] WIN_LEFT_RST   = 16'sd800;
   localparam logic signed [COORD_W-1:0] WIN_BOTTOM_RST = 16'sd800;
   localparam logic signed [COORD_W-1:0] WIN_RIGHT_RST  = 16'sd1600;
   localparam logic signed [COORD_W-1:0] WIN_TOP_RST    = 16'sd1600;

   typedef struct packed {
      logic signed [COORD_W-1:0] win_left;
      logic signed [COORD_W-1:0] win_bottom;
      logic signed [COORD_W-1:0] win_right;
      logic signed [COORD_W-1:0] win_top;
   } win_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
   } seg_type;

   // controller -> datapath
   typedef struct packed {
      logic load_in;    // capture the incoming segment
      logic setup;      // choose endpoint/edge, latch differences
      logic mul;        // form the product
      logic absv;       // magnitudes and quotient sign
      logic div_step;   // one restoring division bit
      logic fix;        // sign, add, saturate, write endpoint back
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic both_in;    // both outcodes zero
      logic share_out;  // outcodes share a bit
      logic den_zero;   // chosen axis has zero extent
   } status_type;

   function automatic logic [3:0] outcode(logic signed [COORD_W-1:0] x,
                                          logic signed [COORD_W-1:0] y,
                                          win_type w);
      logic [3:0] c;
      c = '0;
      if (y > w.win_top) begin
         c = c | OC_TOP;
      end else if (y < w.win_bottom) begin
         c = c | OC_BOTTOM;
      end
      if (x > w.win_right) begin
         c = c | OC_RIGHT;
      end else if (x < w.win_left) begin
         c = c | OC_LEFT;
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/lsc_if.sv =====
// Valid/ready channel interfaces for segment words and result words.
// Depends on lsc_pkg for the coordinate width.
interface lsc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [lsc_pkg::COORD_W-1:0]  ax;
   logic signed [lsc_pkg::COORD_W-1:0]  ay;
   logic signed [lsc_pkg::COORD_W-1:0]  bx;
   logic signed [lsc_pkg::COORD_W-1:0]  by;

   modport source (output valid, output ax, output ay, output bx, output by, input ready);
   modport sink   (input valid, input ax, input ay, input bx, input by, output ready);
endinterface

interface lsc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                accepted;
   logic signed [lsc_pkg::COORD_W-1:0]  clip_ax;
   logic signed [lsc_pkg::COORD_W-1:0]  clip_ay;
   logic signed [lsc_pkg::COORD_W-1:0]  clip_bx;
   logic signed [lsc_pkg::COORD_W-1:0]  clip_by;

   modport source (output valid, output accepted, output clip_ax, output clip_ay,
                   output clip_bx, output clip_by, input ready);
   modport sink   (input valid, input accepted, input clip_ax, input clip_ay,
                   input clip_bx, input clip_by, output ready);
endinterface

// ===== rtl/core/lsc_datapath.sv =====
// Clipper datapath: endpoint registers, outcodes, 17x17 multiplier and a
// bit-serial restoring divider. Depends on lsc_pkg.
module lsc_datapath (
   input  logic                 clock,
   input  lsc_pkg::win_type     win,
   input  lsc_pkg::seg_type     seg_in,
   input  lsc_pkg::cmd_type     cmd,
   output lsc_pkg::status_type  status,
   output lsc_pkg::seg_type     seg_out
);

   localparam int CW = lsc_pkg::COORD_W;
   localparam int DW = lsc_pkg::DIFF_W;
   localparam int PW = lsc_pkg::PROD_W;
   localparam int MW = lsc_pkg::MAG_W;
   localparam int SW = PW + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
   localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

   lsc_pkg::seg_type         seg_ff, seg_in_nx;
   logic                     sel_b_ff, sel_b_in;     // moving endpoint B
   logic                     vert_ff, vert_in;       // clipping against top/bottom
   logic signed [CW-1:0]     edge_ff, edge_in;
   logic signed [CW-1:0]     p0_ff, p0_in;
   logic signed [DW-1:0]     dp_ff, dp_in;
   logic signed [DW-1:0]     de_ff, de_in;
   logic signed [DW-1:0]     den_ff, den_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic [MW-1:0]            num_ff, num_in;         // numerator, then quotient
   logic [CW-1:0]            dmag_ff, dmag_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic                     qneg_ff, qneg_in;

   logic [3:0]               c1, c2, co;
   logic                     vert_now;
   logic signed [CW-1:0]     p0_c, p1_c, q0_c, q1_c, edge_c;
   logic signed [PW-1:0]     prod_abs;
   logic signed [DW-1:0]     den_abs;
   logic [DW-1:0]            trial, trial_sub;
   logic                     trial_ge;
   logic signed [PW-1:0]     quo_s, quo_v;
   logic signed [SW-1:0]     sum;
   logic signed [CW-1:0]     sum_sat;

   // outcodes and the choice of endpoint and edge
   always_comb begin
      c1       = lsc_pkg::outcode(seg_ff.ax, seg_ff.ay, win);
      c2       = lsc_pkg::outcode(seg_ff.bx, seg_ff.by, win);
      co       = (c1 != 4'd0) ? c1 : c2;
      vert_now = (co & (lsc_pkg::OC_TOP | lsc_pkg::OC_BOTTOM)) != 4'd0;
      if (vert_now) begin
         p0_c   = seg_ff.ax;
         p1_c   = seg_ff.bx;
         q0_c   = seg_ff.ay;
         q1_c   = seg_ff.by;
         edge_c = ((co & lsc_pkg::OC_TOP) != 4'd0) ? win.win_top : win.win_bottom;
      end else begin
         p0_c   = seg_ff.ay;
         p1_c   = seg_ff.by;
         q0_c   = seg_ff.ax;
         q1_c   = seg_ff.bx;
         edge_c = ((co & lsc_pkg::OC_RIGHT) != 4'd0) ? win.win_right : win.win_left;
      end
      status.both_in   = (c1 | c2) == 4'd0;
      status.share_out = (c1 & c2) != 4'd0;
      status.den_zero  = (q1_c == q0_c);
   end

   // arithmetic
   always_comb begin
      prod_abs  = prod_ff[PW-1] ? -prod_ff : prod_ff;
      den_abs   = den_ff[DW-1] ? -den_ff : den_ff;
      trial     = {rem_ff, num_ff[MW-1]};
      trial_sub = trial - {1'b0, dmag_ff};
      trial_ge  = trial >= {1'b0, dmag_ff};
      quo_s     = signed'({{(PW-MW){1'b0}}, num_ff});
      quo_v     = qneg_ff ? -quo_s : quo_s;
      sum       = SW'(p0_ff) + SW'(quo_v);
      if (sum > SAT_HI) begin
         sum_sat = CW'(SAT_HI);
      end else if (sum < SAT_LO) begin
         sum_sat = CW'(SAT_LO);
      end else begin
         sum_sat = CW'(sum);
      end
   end

   always_comb begin
      seg_in_nx = seg_ff;
      sel_b_in  = sel_b_ff;
      vert_in   = vert_ff;
      edge_in   = edge_ff;
      p0_in     = p0_ff;
      dp_in     = dp_ff;
      de_in     = de_ff;
      den_in    = den_ff;
      prod_in   = prod_ff;
      num_in    = num_ff;
      dmag_in   = dmag_ff;
      rem_in    = rem_ff;
      qneg_in   = qneg_ff;
      if (cmd.load_in) begin
         seg_in_nx = seg_in;
      end
      if (cmd.setup) begin
         sel_b_in = (c1 == 4'd0);
         vert_in  = vert_now;
         edge_in  = edge_c;
         p0_in    = p0_c;
         dp_in    = DW'(p1_c) - DW'(p0_c);
         de_in    = DW'(edge_c) - DW'(q0_c);
         den_in   = DW'(q1_c) - DW'(q0_c);
      end
      if (cmd.mul) begin
         prod_in = PW'(dp_ff) * PW'(de_ff);
      end
      if (cmd.absv) begin
         num_in  = prod_abs[MW-1:0];
         dmag_in = den_abs[CW-1:0];
         rem_in  = '0;
         qneg_in = prod_ff[PW-1] ^ den_ff[DW-1];
      end
      if (cmd.div_step) begin
         num_in = {num_ff[MW-2:0], trial_ge};
         rem_in = trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
      end
      if (cmd.fix) begin
         case ({sel_b_ff, vert_ff})
            2'b00: begin seg_in_nx.ay = sum_sat; seg_in_nx.ax = edge_ff; end
            2'b01: begin seg_in_nx.ax = sum_sat; seg_in_nx.ay = edge_ff; end
            2'b10: begin seg_in_nx.by = sum_sat; seg_in_nx.bx = edge_ff; end
            2'b11: begin seg_in_nx.bx = sum_sat; seg_in_nx.by = edge_ff; end
            default: begin seg_in_nx = seg_ff; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      seg_ff   <= seg_in_nx;
      sel_b_ff <= sel_b_in;
      vert_ff  <= vert_in;
      edge_ff  <= edge_in;
      p0_ff    <= p0_in;
      dp_ff    <= dp_in;
      de_ff    <= de_in;
      den_ff   <= den_in;
      prod_ff  <= prod_in;
      num_ff   <= num_in;
      dmag_ff  <= dmag_in;
      rem_ff   <= rem_in;
      qneg_ff  <= qneg_in;
   end

   assign seg_out = seg_ff;

endmodule

// ===== rtl/core/lsc_ctrl.sv =====
// Clipper controller: one-hot sequencer over check, multiply, divide and
// write-back, with the clip step and divider bit counters. Depends on lsc_pkg.
module lsc_ctrl #(
   parameter int MAX_CLIP_STEPS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 out_free,     // output register can take a word
   input  lsc_pkg::status_type  status,
   output lsc_pkg::cmd_type     cmd,
   output logic                 load_out,
   output logic                 accept_flag
);

   localparam int STEP_W = $clog2(MAX_CLIP_STEPS + 1);
   localparam int CNT_W  = lsc_pkg::DIV_CNT_W;
   localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_CLIP_STEPS);
   localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(lsc_pkg::MAG_W - 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_MUL   = 7'b0000100,
      S_ABS   = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_FIX   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               acc_ff, acc_in;

   always_comb begin
      state_in = state_ff;
      steps_in = steps_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      cmd      = '0;
      load_out = 1'b0;
      in_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = !reset;
            if (in_valid && !reset) begin
               cmd.load_in = 1'b1;
               steps_in    = '0;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.both_in) begin
               acc_in   = 1'b1;
               state_in = S_DONE;
            end else if (status.share_out || steps_ff == STEP_MAX || status.den_zero) begin
               acc_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               cmd.setup = 1'b1;
               steps_in  = steps_ff + 1'b1;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ABS;
         end
         S_ABS: begin
            cmd.absv = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_CHECK;
         end
         S_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         steps_ff <= '0;
         cnt_ff   <= '0;
         acc_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         steps_ff <= steps_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
      end
   end

   assign accept_flag = acc_ff;

   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= STEP_MAX)
      else $error("clip step count past limit");

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      cmd.setup |=> steps_ff == $past(steps_ff) + 1'b1 && state_ff == S_MUL)
      else $error("clip step not counted");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      cmd.absv |=> state_ff == S_DIV && cnt_ff == '0)
      else $error("divider bit count not cleared");

   a_load_new: assert property (@(posedge clock) disable iff (reset)
      cmd.load_in |=> state_ff == S_CHECK && steps_ff == '0)
      else $error("new segment did not start clean");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free && !in_ready)
      else $error("result written into a full output register");

endmodule

// ===== rtl/core/line_segment_clipper.sv =====
// Top level of the Cohen-Sutherland line segment clipper: window registers,
// output register and the controller/datapath pair. Depends on lsc_pkg, lsc_if,
// lsc_ctrl and lsc_datapath.
//
//   channel  dir  handshake                 word
//   req_ch   in   valid/ready               ax, ay, bx, by      (Q11.4)
//   rsp_ch   out  valid/ready               accepted, clip_ax..clip_by
//   csr_*    in   csr_we, no back-pressure  csr_index, csr_wdata (window edges)
//
// Sequence: a segment is taken, its outcodes are checked, and each clip step runs
//   check, multiply, magnitude, the bit-serial divider's 32 quotient bits and
//   write-back. A segment makes at most MAX_CLIP_STEPS clip steps.
// Reset: synchronous, active high; window returns to 800/800/1600/1600.
// Stalls: one segment in flight; req_ch is ready only while idle. A held
//   result word waits in the output register while the next segment is
//   taken; a finished segment waits only if that register is still full.
module line_segment_clipper #(
   parameter int MAX_CLIP_STEPS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lsc_req_if.sink                               req_ch,
   lsc_rsp_if.source                             rsp_ch,
   input  logic                                  csr_we,
   input  logic [lsc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lsc_pkg::COORD_W-1:0]           csr_wdata
);

   lsc_pkg::win_type     win_ff, win_in;
   lsc_pkg::seg_type     seg_req, seg_cur;
   lsc_pkg::cmd_type     cmd;
   lsc_pkg::status_type  status;

   logic                 load_out, accept_flag, out_free;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 acc_ff, acc_in;
   lsc_pkg::seg_type     clip_ff, clip_in;

   // window registers; all four indexes are in use
   always_comb begin
      win_in = win_ff;
      if (csr_we) begin
         case (csr_index)
            lsc_pkg::CSR_WIN_LEFT:   win_in.win_left   = signed'(csr_wdata);
            lsc_pkg::CSR_WIN_BOTTOM: win_in.win_bottom = signed'(csr_wdata);
            lsc_pkg::CSR_WIN_RIGHT:  win_in.win_right  = signed'(csr_wdata);
            lsc_pkg::CSR_WIN_TOP:    win_in.win_top    = signed'(csr_wdata);
            default:                 win_in = win_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.win_left   <= lsc_pkg::WIN_LEFT_RST;
         win_ff.win_bottom <= lsc_pkg::WIN_BOTTOM_RST;
         win_ff.win_right  <= lsc_pkg::WIN_RIGHT_RST;
         win_ff.win_top    <= lsc_pkg::WIN_TOP_RST;
      end else begin
         win_ff <= win_in;
      end
   end

   assign seg_req.ax = req_ch.ax;
   assign seg_req.ay = req_ch.ay;
   assign seg_req.bx = req_ch.bx;
   assign seg_req.by = req_ch.by;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   lsc_ctrl #(
      .MAX_CLIP_STEPS (MAX_CLIP_STEPS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .out_free    (out_free),
      .status      (status),
      .cmd         (cmd),
      .load_out    (load_out),
      .accept_flag (accept_flag)
   );

   lsc_datapath u_dp (
      .clock   (clock),
      .win     (win_ff),
      .seg_in  (seg_req),
      .cmd     (cmd),
      .status  (status),
      .seg_out (seg_cur)
   );

   // output register; a rejected segment reports all-zero coordinates
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      acc_in       = acc_ff;
      clip_in      = clip_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         acc_in       = accept_flag;
         clip_in      = accept_flag ? seg_cur : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff  <= acc_in;
      clip_ff <= clip_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.accepted = acc_ff;
   assign rsp_ch.clip_ax  = clip_ff.ax;
   assign rsp_ch.clip_ay  = clip_ff.ay;
   assign rsp_ch.clip_bx  = clip_ff.bx;
   assign rsp_ch.clip_by  = clip_ff.by;

endmodule
